// File: design/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on the same edge as the trigger
`define ASSERT_NOW(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed");

// condition holds on the edge after the trigger
`define ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

// condition holds on the edge after the trigger, checked during reset too
`define ASSERT_NEXT_ALWAYS(label, clk, trig, cond) \
    label: assert property (@(posedge clk) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

// File: design/srcv_pkg.sv
// package: types, constants and helper functions of the random cv pair
package srcv_pkg;

    localparam int CV_W    = 12;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 16;
    localparam int LAG_W   = 17;
    localparam int CFG_W   = 17;
    localparam int IDX_W   = 3;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 24;

    localparam logic [VAL_W-1:0] RNG_SEED = 32'h8badf00d;

    localparam logic [CNT_W-1:0] RST_TICK_DIVIDER = 16'd48;
    localparam logic [CNT_W-1:0] RST_PERIOD_A     = 16'd14286;
    localparam logic [CNT_W-1:0] RST_PERIOD_B     = 16'd9091;
    localparam logic [LAG_W-1:0] RST_LAG_A        = 17'd5;
    localparam logic [LAG_W-1:0] RST_LAG_B        = 17'd7;

    localparam logic signed [15:0] CV_MIN = -16'sd2048;
    localparam logic signed [15:0] CV_MAX = 16'sd2047;

    typedef enum logic [IDX_W-1:0] {
        CFG_TICK_DIVIDER = 3'd0,
        CFG_PERIOD_A     = 3'd1,
        CFG_PERIOD_B     = 3'd2,
        CFG_LAG_A        = 3'd3,
        CFG_LAG_B        = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CNT_W-1:0] tick_divider;
        logic [CNT_W-1:0] period_a;
        logic [CNT_W-1:0] period_b;
        logic [LAG_W-1:0] lag_a;
        logic [LAG_W-1:0] lag_b;
    } t_cfg;

    function automatic logic [VAL_W-1:0] xorshift32(input logic [VAL_W-1:0] x);
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

    // q16 value to 12-bit code, truncated toward zero and clamped
    function automatic logic [CV_W-1:0] cv_code(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] b;
        logic signed [15:0] q;
        logic [CV_W-1:0] c;
        b = v + {16'd0, {16{v[VAL_W-1]}}};
        q = $signed(b[31:16]);
        if (q < CV_MIN) begin
            c = 12'h800;
        end else if (q > CV_MAX) begin
            c = 12'h7ff;
        end else begin
            c = q[CV_W-1:0];
        end
        return c;
    endfunction

endpackage

// File: design/srcv_cfg.sv
// configuration register file
module srcv_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [srcv_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [srcv_pkg::CFG_W-1:0]  i_cfg_data,
    output srcv_pkg::t_cfg              o_cfg
);
    import srcv_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TICK_DIVIDER: n_cfg.tick_divider = i_cfg_data[CNT_W-1:0];
                CFG_PERIOD_A:     n_cfg.period_a     = i_cfg_data[CNT_W-1:0];
                CFG_PERIOD_B:     n_cfg.period_b     = i_cfg_data[CNT_W-1:0];
                CFG_LAG_A:        n_cfg.lag_a        = i_cfg_data[LAG_W-1:0];
                CFG_LAG_B:        n_cfg.lag_b        = i_cfg_data[LAG_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_divider <= RST_TICK_DIVIDER;
            r_cfg.period_a     <= RST_PERIOD_A;
            r_cfg.period_b     <= RST_PERIOD_B;
            r_cfg.lag_a        <= RST_LAG_A;
            r_cfg.lag_b        <= RST_LAG_B;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/srcv_lfo.sv
// one lagged sample-and-hold lfo: countdown, target and smoothed value
module srcv_lfo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [srcv_pkg::VAL_W-1:0]  i_rand,
    input  logic [srcv_pkg::CNT_W-1:0]  i_period,
    input  logic [srcv_pkg::LAG_W-1:0]  i_lag,
    output logic                        o_draw,
    output logic [srcv_pkg::CV_W-1:0]   o_cv
);
    import srcv_pkg::*;

    logic [CNT_W-1:0]    r_count;
    logic [VAL_W-1:0]    r_target;
    logic [VAL_W-1:0]    r_value;
    logic [CNT_W-1:0]    n_count;
    logic [VAL_W-1:0]    n_target;
    logic [VAL_W-1:0]    n_value;
    logic signed [32:0]  w_delta;
    logic signed [50:0]  w_prod;
    logic signed [50:0]  w_bias;

    assign o_draw = (r_count == '0);

    always_comb begin
        n_count  = r_count;
        n_target = r_target;
        n_value  = r_value;
        if (i_step) begin
            if (o_draw) begin
                n_count  = i_period;
                // -2048 + low 12 bits, as q16
                n_target = {{5{~i_rand[11]}}, i_rand[10:0], 16'd0};
            end else begin
                n_count  = r_count - 1'b1;
            end
            n_value = r_value + w_bias[47:16];
        end
    end

    always_comb begin
        w_delta = $signed({n_target[VAL_W-1], n_target})
                - $signed({r_value[VAL_W-1], r_value});
        w_prod  = w_delta * $signed({1'b0, i_lag});
        // round toward zero before the shift
        w_bias  = w_prod + $signed({35'd0, {16{w_prod[50]}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_target <= '0;
            r_value  <= '0;
        end else begin
            r_count  <= n_count;
            r_target <= n_target;
            r_value  <= n_value;
        end
    end

    assign o_cv = cv_code(n_value);

endmodule

// File: design/smooth_random_cv_pair.sv
// top level: smooth random cv pair, two lagged sample-and-hold lfos
//
// usage:
// - slave side takes one tick word per cycle unless stalled; i_s_tdata[0]
//   is advance (1 = normal tick, 0 = muted tick that changes nothing)
// - master side returns one word per tick: o_m_tdata holds cv_a in the low
//   12 bits and cv_b above it, o_m_tuser is 1 when that tick stepped the lfos
// - an accepted tick is held in the input register, is worked once the result
//   register is free or being read, and then shows on the master side
// - throughput is one word per cycle unless the receiver stalls; the lfo
//   state loop (xorshift draw, one 33x18 multiply, the add) is unregistered
// - when the receiver stalls the result register holds, one more word waits
//   in the input register, then o_s_tready drops
// - reset (synchronous, active low) empties both registers, loads the
//   register defaults, seeds the generator and clears the lfo state
// - the configuration port writes one register per cycle with no wait;
//   write only while no word is in flight
module smooth_random_cv_pair (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [srcv_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [srcv_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [srcv_pkg::S_DATA_W-1:0]  i_s_tdata,  // advance
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [srcv_pkg::M_DATA_W-1:0]  o_m_tdata,  // cv_a, cv_b
    output logic                           o_m_tuser   // updated
);
    import srcv_pkg::*;

    t_cfg             w_cfg;
    logic             r_in_valid;
    logic             r_adv;
    logic             r_out_valid;
    logic [CV_W-1:0]  r_cv_a;
    logic [CV_W-1:0]  r_cv_b;
    logic             r_upd;
    logic [CNT_W-1:0] r_div;
    logic [VAL_W-1:0] r_rng;
    logic [CNT_W-1:0] n_div;
    logic [VAL_W-1:0] n_rng;
    logic             w_move;
    logic             w_fire;
    logic [VAL_W-1:0] w_xs1;
    logic [VAL_W-1:0] w_xs2;
    logic             w_draw_a;
    logic             w_draw_b;
    logic [VAL_W-1:0] w_rand_b;
    logic [CV_W-1:0]  w_cv_a;
    logic [CV_W-1:0]  w_cv_b;

    srcv_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign w_move     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_move;
    assign w_fire     = w_move && r_adv && !(r_div < w_cfg.tick_divider);

    assign w_xs1    = xorshift32(r_rng);
    assign w_xs2    = xorshift32(w_xs1);
    assign w_rand_b = w_draw_a ? w_xs2 : w_xs1;

    srcv_lfo u_lfo_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_fire),
        .i_rand   (w_xs1),
        .i_period (w_cfg.period_a),
        .i_lag    (w_cfg.lag_a),
        .o_draw   (w_draw_a),
        .o_cv     (w_cv_a)
    );

    srcv_lfo u_lfo_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_fire),
        .i_rand   (w_rand_b),
        .i_period (w_cfg.period_b),
        .i_lag    (w_cfg.lag_b),
        .o_draw   (w_draw_b),
        .o_cv     (w_cv_b)
    );

    always_comb begin
        n_div = r_div;
        n_rng = r_rng;
        if (w_move && r_adv) begin
            if (w_fire) begin
                n_div = '0;
            end else begin
                n_div = r_div + 1'b1;
            end
        end
        if (w_fire) begin
            if (w_draw_a && w_draw_b) begin
                n_rng = w_xs2;
            end else if (w_draw_a || w_draw_b) begin
                n_rng = w_xs1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_div       <= RST_TICK_DIVIDER;
            r_rng       <= RNG_SEED;
        end else begin
            r_div <= n_div;
            r_rng <= n_rng;
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_adv <= i_s_tdata[0];
        end
        if (w_move) begin
            r_cv_a <= w_cv_a;
            r_cv_b <= w_cv_b;
            r_upd  <= w_fire;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_cv_b, r_cv_a};
    assign o_m_tuser  = r_upd;

endmodule

// File: design/srcv_chk.sv
// port checker for the random cv pair, bound to the top level
`include "assert_macros.svh"

module srcv_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [srcv_pkg::S_DATA_W-1:0]  i_s_tdata,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [srcv_pkg::M_DATA_W-1:0]  o_m_tdata,
    input logic                           o_m_tuser
);
    import srcv_pkg::*;

    logic [1:0]          r_pend;
    logic [1:0]          n_pend;
    logic                r_have;
    logic [M_DATA_W-1:0] r_last;
    logic                w_in;
    logic                w_out;
    logic                w_mute_adv;

    assign w_in       = i_s_tvalid && o_s_tready;
    assign w_out      = o_m_tvalid && i_m_tready;
    assign w_mute_adv = w_in && !i_s_tdata[0];

    always_comb begin
        n_pend = r_pend;
        if (w_in && !w_out) begin
            n_pend = r_pend + 1'b1;
        end else if (w_out && !w_in) begin
            n_pend = r_pend - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_have <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (w_out) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out) begin
            r_last <= o_m_tdata;
        end
    end

    // result word held while stalled
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
    // at most two words in flight, and a shown word has a tick behind it
    `ASSERT_NOW(a_pend, i_clk, i_rst_n, 1'b1,
        (r_pend != 2'd3) && (!o_m_tvalid || (r_pend != 2'd0)))
    // the codes only move on a word that stepped the lfos
    `ASSERT_NOW(a_held_cv, i_clk, i_rst_n, w_out && r_have && !o_m_tuser,
        o_m_tdata == r_last)
    // no full buffer may leave ready high past a stall
    `ASSERT_NOW(a_ready, i_clk, i_rst_n, r_pend == 2'd2 && !i_m_tready, !o_s_tready)
    // nothing shows right after reset
    `ASSERT_NEXT_ALWAYS(a_reset, i_clk, !i_rst_n, !o_m_tvalid && !w_mute_adv ||
        !o_m_tvalid)

endmodule

bind smooth_random_cv_pair srcv_chk u_srcv_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// File: verif/tb_smooth_random_cv_pair.sv
// testbench for smooth_random_cv_pair: random stream stalls, checked against an lfo predictor
`timescale 1ns / 1ps

module tb_smooth_random_cv_pair;
    import srcv_pkg::*;

    localparam longint Q16_ONE     = 65536;
    localparam int     NUM_PHASES  = 12;
    localparam int     PHASE_WORDS = 100;
    localparam int     LONG_HOLD   = 300;
    localparam int     QUIET_LIMIT = 2000;
    localparam logic [IDX_W-1:0] CFG_FIRST_UNUSED = IDX_W'(CFG_LAG_B + 1);
    localparam logic [LAG_W-1:0] LAG_ONE = 17'd65536;
    localparam logic [LAG_W-1:0] LAG_TOP = {LAG_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_TOP = {CNT_W{1'b1}};

    typedef struct packed {
        logic [CV_W-1:0] cv_a;
        logic [CV_W-1:0] cv_b;
        logic            updated;
    } t_cv_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_W-1:0]    i_cfg_data = '0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata = '0;  // advance
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;       // cv_a, cv_b
    logic                o_m_tuser;       // updated

    smooth_random_cv_pair DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    // predictor state
    t_cfg             cfg_shadow;
    logic [CNT_W-1:0] fire_count;
    logic [VAL_W-1:0] noise_reg;
    logic [VAL_W-1:0] lfo_val [2];
    logic [VAL_W-1:0] lfo_goal [2];
    logic [CNT_W-1:0] hold_steps [2];

    bit       pending_ticks [$];
    t_cv_word cv_words_due [$];

    int errors = 0;
    int quiet_cycles = 0;
    int gap_left = 0;
    int stall_left = 0;
    int long_hold_asked = 0;
    int long_hold_served = 0;
    bit calm = 1'b0;
    bit sender_hold = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void step_lag_lfo(int k, logic [CNT_W-1:0] per, logic [LAG_W-1:0] lag);
        longint diff;
        longint move;
        if (hold_steps[k] == '0) begin
            noise_reg = noise_reg ^ (noise_reg << 13);
            noise_reg = noise_reg ^ (noise_reg >> 17);
            noise_reg = noise_reg ^ (noise_reg << 5);
            lfo_goal[k] = VAL_W'((longint'(noise_reg[CV_W-1:0]) + longint'(CV_MIN)) * Q16_ONE);
            hold_steps[k] = per;
        end else begin
            hold_steps[k] = hold_steps[k] - 1'b1;
        end
        diff = longint'($signed(lfo_goal[k])) - longint'($signed(lfo_val[k]));
        move = (diff * longint'(lag)) / Q16_ONE;
        lfo_val[k] = lfo_val[k] + VAL_W'(move);
    endfunction

    function automatic logic [CV_W-1:0] cv_of(logic [VAL_W-1:0] v);
        longint q;
        q = longint'($signed(v)) / Q16_ONE;
        if (q < longint'(CV_MIN)) begin
            q = longint'(CV_MIN);
        end
        if (q > longint'(CV_MAX)) begin
            q = longint'(CV_MAX);
        end
        return q[CV_W-1:0];
    endfunction

    function automatic void predict_cv_word(logic adv);
        t_cv_word w;
        w.updated = 1'b0;
        if (adv) begin
            if (fire_count < cfg_shadow.tick_divider) begin
                fire_count = fire_count + 1'b1;
            end else begin
                fire_count = '0;
                step_lag_lfo(0, cfg_shadow.period_a, cfg_shadow.lag_a);
                step_lag_lfo(1, cfg_shadow.period_b, cfg_shadow.lag_b);
                w.updated = 1'b1;
            end
        end
        w.cv_a = cv_of(lfo_val[0]);
        w.cv_b = cv_of(lfo_val[1]);
        cv_words_due.push_back(w);
    endfunction

    function automatic void check_field(string name, logic [CV_W-1:0] want,
                                        logic [CV_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic logic [CNT_W-1:0] pick_period();
        return ($urandom_range(7) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(12));
    endfunction

    function automatic logic [LAG_W-1:0] pick_lag();
        case ($urandom_range(3))
            0: return LAG_W'($urandom_range(LAG_TOP));
            1: return LAG_W'($urandom_range(255));
            2: return LAG_W'($urandom_range(LAG_ONE, 30000));
            default: return LAG_ONE;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            gap_left   <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                predict_cv_word(i_s_tdata[0]);
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left != 0) begin
                    gap_left   <= gap_left - 1;
                    i_s_tvalid <= 1'b0;
                end else if (!calm && $urandom_range(7) == 0) begin
                    gap_left   <= $urandom_range(10);
                    i_s_tvalid <= 1'b0;
                end else if (!sender_hold && pending_ticks.size() != 0) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= S_DATA_W'(pending_ticks.pop_front());
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left <= 0;
        end else if (long_hold_served != long_hold_asked) begin
            long_hold_served <= long_hold_served + 1;
            stall_left       <= LONG_HOLD;
            i_m_tready       <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (!calm && $urandom_range(7) == 0) begin
            stall_left <= $urandom_range(10);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        t_cv_word want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (cv_words_due.size() == 0) begin
                $display("%0t: unexpected word, expected none got cv_a %h cv_b %h updated %b",
                         $time, o_m_tdata[CV_W-1:0], o_m_tdata[2*CV_W-1:CV_W], o_m_tuser);
                errors++;
            end else begin
                want = cv_words_due.pop_front();
                check_field("cv_a", want.cv_a, o_m_tdata[CV_W-1:0]);
                check_field("cv_b", want.cv_b, o_m_tdata[2*CV_W-1:CV_W]);
                check_field("updated", CV_W'(want.updated), CV_W'(o_m_tuser));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("** smooth_random_cv_pair: FAILED **");
        $finish;
    end

    task automatic queue_ticks(int n, int pct_on);
        repeat (n) pending_ticks.push_back($urandom_range(99) < pct_on);
    endtask

    task automatic settle();
        while (pending_ticks.size() != 0 || i_s_tvalid || cv_words_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_TICK_DIVIDER: cfg_shadow.tick_divider = val[CNT_W-1:0];
            CFG_PERIOD_A:     cfg_shadow.period_a = val[CNT_W-1:0];
            CFG_PERIOD_B:     cfg_shadow.period_b = val[CNT_W-1:0];
            CFG_LAG_A:        cfg_shadow.lag_a = val[LAG_W-1:0];
            CFG_LAG_B:        cfg_shadow.lag_b = val[LAG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic finish_writes();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_settings(logic [CNT_W-1:0] div, logic [CNT_W-1:0] pa,
                                 logic [CNT_W-1:0] pb, logic [LAG_W-1:0] la,
                                 logic [LAG_W-1:0] lb);
        write_reg(CFG_TICK_DIVIDER, CFG_W'(div));
        write_reg(CFG_PERIOD_A, CFG_W'(pa));
        write_reg(CFG_PERIOD_B, CFG_W'(pb));
        write_reg(CFG_LAG_A, CFG_W'(la));
        write_reg(CFG_LAG_B, CFG_W'(lb));
        write_reg(IDX_W'($urandom_range(CFG_FIRST_UNUSED, (1 << IDX_W) - 1)), CFG_W'($urandom));
        finish_writes();
    endtask

    // stimulus
    initial begin
        cfg_shadow = '{tick_divider: RST_TICK_DIVIDER, period_a: RST_PERIOD_A,
                       period_b: RST_PERIOD_B, lag_a: RST_LAG_A, lag_b: RST_LAG_B};
        fire_count = RST_TICK_DIVIDER;
        noise_reg  = RNG_SEED;
        lfo_val    = '{default: '0};
        lfo_goal   = '{default: '0};
        hold_steps = '{default: '0};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // first tick after reset fires, muted ticks in between
        pending_ticks = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        settle();
        load_settings('0, '0, 16'd1, LAG_ONE, LAG_TOP);
        pending_ticks = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        settle();
        load_settings(16'd20, 16'd3, '0, '0, 17'd32768);
        repeat (8) pending_ticks.push_back(1'b1);
        settle();
        // divider top lowered below the running count
        write_reg(CFG_TICK_DIVIDER, CFG_W'(3));
        for (int i = int'(CFG_FIRST_UNUSED); i < (1 << IDX_W); i++) begin
            write_reg(IDX_W'(i), CFG_W'($urandom));
        end
        finish_writes();
        pending_ticks = '{1'b1, 1'b0, 1'b1};
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: load_settings('0, '0, '0, '0, '0);
                1: load_settings('0, CNT_TOP, CNT_TOP, LAG_TOP, LAG_TOP);
                2: load_settings(CNT_TOP, CNT_TOP, CNT_TOP, LAG_ONE, LAG_ONE);
                default: load_settings(($urandom_range(7) == 0) ? CNT_W'($urandom)
                                                                : CNT_W'($urandom_range(3)),
                                       pick_period(), pick_period(), pick_lag(), pick_lag());
            endcase
            calm = (p == NUM_PHASES - 1) || ($urandom_range(4) == 0);
            if (p == 4) begin
                queue_ticks(PHASE_WORDS, 90);
                long_hold_asked++;
            end else if (p == 6) begin
                queue_ticks(PHASE_WORDS / 2, 90);
                while (pending_ticks.size() > PHASE_WORDS / 4) @(negedge i_clk);
                sender_hold = 1'b1;
                while (i_s_tvalid || cv_words_due.size() != 0) @(negedge i_clk);
                repeat (5) @(negedge i_clk);
                sender_hold = 1'b0;
                queue_ticks(PHASE_WORDS / 2, 90);
            end else begin
                queue_ticks(PHASE_WORDS, 90);
            end
            settle();
        end

        repeat (4) @(negedge i_clk);
        if (errors == 0 && cv_words_due.size() == 0) begin
            $display("** smooth_random_cv_pair: PASSED **");
        end else begin
            $display("** smooth_random_cv_pair: FAILED **");
        end
        $finish;
    end

endmodule
